FILE: design/obet_pkg.sv
// Package for the order book event tracker: payload structs, codes, sizes.
// No dependencies.
package obet_pkg;

    localparam int MAX_ORDERS = 256;
    localparam int SLOT_W     = $clog2(MAX_ORDERS);
    // slot word: key, side, price, qty
    localparam int ENTRY_W    = 64 + 1 + 31 + 31;

    localparam logic [2:0] CMD_ACCEPTED = 3'd0;
    localparam logic [2:0] CMD_REJECTED = 3'd1;
    localparam logic [2:0] CMD_RESTED   = 3'd2;
    localparam logic [2:0] CMD_PARTIAL  = 3'd3;
    localparam logic [2:0] CMD_TRADE    = 3'd4;
    localparam logic [2:0] CMD_FULL     = 3'd5;
    localparam logic [2:0] CMD_CANCEL   = 3'd6;
    localparam logic [2:0] CMD_UNKNOWN  = 3'd7;

    localparam logic [1:0] ST_APPLIED  = 2'd0;
    localparam logic [1:0] ST_IGNORED  = 2'd1;
    localparam logic [1:0] ST_REJECTED = 2'd2;

    localparam logic [3:0] RS_NONE      = 4'd0;
    localparam logic [3:0] RS_GAP       = 4'd1;
    localparam logic [3:0] RS_UNK_TYPE  = 4'd2;
    localparam logic [3:0] RS_NO_LIQ    = 4'd3;
    localparam logic [3:0] RS_BAD_ORDER = 4'd4;
    localparam logic [3:0] RS_BAD_TRADE = 4'd5;
    localparam logic [3:0] RS_UNK_CONTRA = 4'd6;
    localparam logic [3:0] RS_OVERFILL  = 4'd7;
    localparam logic [3:0] RS_UNK_CANCEL = 4'd8;
    localparam logic [3:0] RS_FULL      = 4'd9;

    localparam logic [30:0] QTY_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [63:0]        seq_num;
        logic [63:0]        order_key;
        logic [63:0]        contra_key;
        logic [63:0]        trade_ident;
        logic [31:0]        instrument;
        logic [1:0]         side_code;
        logic signed [31:0] price;
        logic signed [31:0] remaining_qty;
        logic signed [31:0] trade_qty;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  reason;
        logic        trade_valid;
        logic [63:0] trade_out_ident;
        logic [30:0] best_bid_price;
        logic [30:0] best_bid_qty;
        logic [30:0] best_ask_price;
        logic [30:0] best_ask_qty;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic clr_scan;   // start a table pass
        logic scan_rd;    // issue read of scan index
        logic scan_acc;   // absorb read data of previous index
        logic decide;     // evaluate event after lookup pass
        logic write;      // write back the chosen slot
        logic clr_best;   // start top-of-book pass
        logic best_acc;   // fold read data into best bid/ask
        logic finish;     // build result
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // last index issued
    } t_sts;

endpackage

FILE: design/obet_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module obet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: design/obet_datapath.sv
// Datapath: event register, slot memory, valid bits, lookup and best-price scans.
// Depends on obet_pkg and obet_ram.
module obet_datapath import obet_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_ctl      i_ctl,
    output t_sts      o_sts,
    output t_out_item o_result
);
    t_in_item r_ev;
    logic [63:0] r_last_seq, n_last_seq;
    logic [MAX_ORDERS-1:0] r_valid, n_valid;
    logic [SLOT_W-1:0] r_idx, n_idx, r_pidx;

    logic r_hit_found, n_hit_found, r_free_found, n_free_found;
    logic [SLOT_W-1:0] r_hit_idx, n_hit_idx, r_free_idx, n_free_idx;
    logic [30:0] r_hit_qty, n_hit_qty;
    logic r_hit_side, n_hit_side;
    logic [30:0] r_hit_price, n_hit_price;
    logic [63:0] r_hit_key, n_hit_key;

    logic [1:0] r_status, n_status;
    logic [3:0] r_reason, n_reason;
    logic r_tvalid, n_tvalid;

    logic [30:0] r_bid_p, n_bid_p, r_ask_p, n_ask_p;
    logic [31:0] r_bid_q, n_bid_q, r_ask_q, n_ask_q;
    t_out_item r_out, n_out;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [63:0] rd_key;
    logic rd_side;
    logic [30:0] rd_price, rd_qty;
    logic rd_valid;
    logic [63:0] look_key;

    assign {rd_key, rd_side, rd_price, rd_qty} = ram_rdata;
    assign rd_valid = r_valid[r_pidx];
    assign look_key = (r_ev.cmd == CMD_TRADE) ? r_ev.contra_key : r_ev.order_key;

    obet_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ORDERS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_sts.scan_last = (r_idx == SLOT_W'(MAX_ORDERS - 1));
    assign o_result = r_out;

    always_comb begin
        logic [63:0] next_seq;
        logic [SLOT_W-1:0] wslot;
        logic [31:0] sum;
        next_seq = r_last_seq + 64'd1;
        wslot    = r_hit_found ? r_hit_idx : r_free_idx;
        sum      = '0;
        n_last_seq = r_last_seq;
        n_valid = r_valid;
        n_idx = r_idx;
        n_hit_found = r_hit_found; n_hit_idx = r_hit_idx;
        n_free_found = r_free_found; n_free_idx = r_free_idx;
        n_hit_qty = r_hit_qty; n_hit_side = r_hit_side;
        n_hit_price = r_hit_price; n_hit_key = r_hit_key;
        n_status = r_status; n_reason = r_reason; n_tvalid = r_tvalid;
        n_bid_p = r_bid_p; n_bid_q = r_bid_q; n_ask_p = r_ask_p; n_ask_q = r_ask_q;
        n_out = r_out;
        ram_we = 1'b0;
        ram_addr = r_idx;
        ram_wdata = {r_hit_key, r_hit_side, r_hit_price, r_hit_qty};

        if (i_ctl.clr_scan) begin
            n_idx = '0;
            n_hit_found = 1'b0;
            n_free_found = 1'b0;
        end
        if (i_ctl.scan_rd && !o_sts.scan_last) begin
            n_idx = r_idx + SLOT_W'(1);
        end
        if (i_ctl.scan_acc) begin
            // keep the whole hit entry so a trade can rewrite it in place
            if (rd_valid && rd_key == look_key && !r_hit_found) begin
                n_hit_found = 1'b1; n_hit_idx = r_pidx; n_hit_qty = rd_qty;
                n_hit_key = rd_key; n_hit_side = rd_side; n_hit_price = rd_price;
            end
            if (!rd_valid && !r_free_found) begin
                n_free_found = 1'b1; n_free_idx = r_pidx;
            end
        end
        if (i_ctl.decide) begin
            n_status = ST_APPLIED; n_reason = RS_NONE; n_tvalid = 1'b0;
            if (r_ev.seq_num != next_seq) begin
                n_status = ST_REJECTED; n_reason = RS_GAP;
            end else begin
                case (r_ev.cmd)
                    CMD_ACCEPTED, CMD_REJECTED: n_status = ST_IGNORED;
                    CMD_RESTED, CMD_PARTIAL: begin
                        if (r_ev.remaining_qty <= 0 || r_ev.side_code[1]) begin
                            n_status = ST_REJECTED; n_reason = RS_NO_LIQ;
                        end else if (r_ev.order_key == '0 || r_ev.price <= 0) begin
                            n_status = ST_REJECTED; n_reason = RS_BAD_ORDER;
                        end else if (!r_hit_found && !r_free_found) begin
                            n_status = ST_REJECTED; n_reason = RS_FULL;
                        end else begin
                            n_hit_key = r_ev.order_key;
                            n_hit_side = r_ev.side_code[0];
                            n_hit_price = r_ev.price[30:0];
                            n_hit_qty = r_ev.remaining_qty[30:0];
                            n_valid[wslot] = 1'b1;
                        end
                    end
                    CMD_TRADE: begin
                        if (r_ev.trade_qty <= 0 || r_ev.contra_key == '0) begin
                            n_status = ST_REJECTED; n_reason = RS_BAD_TRADE;
                        end else if (!r_hit_found) begin
                            n_status = ST_REJECTED; n_reason = RS_UNK_CONTRA;
                        end else if ({1'b0, r_hit_qty} < r_ev.trade_qty[31:0]) begin
                            n_status = ST_REJECTED; n_reason = RS_OVERFILL;
                        end else begin
                            n_tvalid = 1'b1;
                            if (r_hit_qty == r_ev.trade_qty[30:0]) begin
                                n_valid[r_hit_idx] = 1'b0;
                            end
                        end
                    end
                    CMD_FULL: begin
                        if (!r_hit_found) n_status = ST_IGNORED;
                        else n_valid[r_hit_idx] = 1'b0;
                    end
                    CMD_CANCEL: begin
                        if (!r_hit_found) begin
                            n_status = ST_REJECTED; n_reason = RS_UNK_CANCEL;
                        end else begin
                            n_valid[r_hit_idx] = 1'b0;
                        end
                    end
                    default: begin
                        n_status = ST_REJECTED; n_reason = RS_UNK_TYPE;
                    end
                endcase
            end
            if (r_ev.seq_num == next_seq && n_status != ST_REJECTED) begin
                n_last_seq = r_ev.seq_num;
            end
        end
        // write back: insert/overwrite writes full entry, trade only quantity
        if (i_ctl.write && r_status == ST_APPLIED) begin
            if (r_ev.cmd == CMD_RESTED || r_ev.cmd == CMD_PARTIAL) begin
                ram_we = 1'b1; ram_addr = wslot;
            end else if (r_ev.cmd == CMD_TRADE && r_valid[r_hit_idx]) begin
                ram_we = 1'b1; ram_addr = r_hit_idx;
                ram_wdata = {r_hit_key, r_hit_side, r_hit_price,
                             r_hit_qty - r_ev.trade_qty[30:0]};
            end
        end
        if (i_ctl.clr_best) begin
            n_bid_p = '0; n_bid_q = '0; n_ask_p = '0; n_ask_q = '0;
        end
        if (i_ctl.best_acc && rd_valid) begin
            if (!rd_side) begin
                sum = r_bid_q + {1'b0, rd_qty};
                if (r_bid_p == '0 || rd_price > r_bid_p) begin
                    n_bid_p = rd_price; n_bid_q = {1'b0, rd_qty};
                end else if (rd_price == r_bid_p) begin
                    n_bid_q = sum[31] ? {1'b0, QTY_MAX} : sum;
                end
            end else begin
                sum = r_ask_q + {1'b0, rd_qty};
                if (r_ask_p == '0 || rd_price < r_ask_p) begin
                    n_ask_p = rd_price; n_ask_q = {1'b0, rd_qty};
                end else if (rd_price == r_ask_p) begin
                    n_ask_q = sum[31] ? {1'b0, QTY_MAX} : sum;
                end
            end
        end
        if (i_ctl.finish) begin
            n_out.status = r_status;
            n_out.reason = r_reason;
            n_out.trade_valid = r_tvalid;
            n_out.trade_out_ident = r_tvalid ? r_ev.trade_ident : '0;
            n_out.best_bid_price = r_bid_p;
            n_out.best_bid_qty = r_bid_q[30:0];
            n_out.best_ask_price = r_ask_p;
            n_out.best_ask_qty = r_ask_q[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= '0;
            r_valid <= '0;
        end else begin
            r_last_seq <= n_last_seq;
            r_valid <= n_valid;
        end
        if (i_ctl.load) r_ev <= i_item;
        r_pidx <= r_idx;
        r_idx <= n_idx;
        r_hit_found <= n_hit_found; r_hit_idx <= n_hit_idx;
        r_free_found <= n_free_found; r_free_idx <= n_free_idx;
        r_hit_qty <= n_hit_qty; r_hit_side <= n_hit_side;
        r_hit_price <= n_hit_price; r_hit_key <= n_hit_key;
        r_status <= n_status; r_reason <= n_reason; r_tvalid <= n_tvalid;
        r_bid_p <= n_bid_p; r_bid_q <= n_bid_q;
        r_ask_p <= n_ask_p; r_ask_q <= n_ask_q;
        r_out <= n_out;
    end
endmodule

FILE: design/obet_ctrl.sv
// Controller: sequences lookup pass, decision, write-back, best-price pass, output.
// Depends on obet_pkg.
module obet_ctrl import obet_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOOK  = 8'b0000_0010,
        S_LTAIL = 8'b0000_0100,
        S_DEC   = 8'b0000_1000,
        S_WR    = 8'b0001_0000,
        S_BEST  = 8'b0010_0000,
        S_BTAIL = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic r_ovalid, n_ovalid;
    logic r_rd_d, n_rd_d;
    logic out_free;

    // result register frees when taken, so the next item may start meanwhile
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;

    always_comb begin
        n_state = r_state;
        n_ovalid = r_ovalid && !i_ready;
        o_ctl = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.load = 1'b1; o_ctl.clr_scan = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_ctl.scan_rd = 1'b1;
                if (i_sts.scan_last) n_state = S_LTAIL;
            end
            S_LTAIL: begin
                o_ctl.scan_acc = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                o_ctl.decide = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_ctl.write = 1'b1; o_ctl.clr_scan = 1'b1; o_ctl.clr_best = 1'b1;
                n_state = S_BEST;
            end
            S_BEST: begin
                o_ctl.scan_rd = 1'b1;
                if (i_sts.scan_last) n_state = S_BTAIL;
            end
            S_BTAIL: begin
                o_ctl.best_acc = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_ctl.finish = 1'b1; n_ovalid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // read data arrives in the cycle after its index; no accumulate on the first read of a pass
        if (r_state == S_LOOK && r_rd_d) o_ctl.scan_acc = 1'b1;
        if (r_state == S_BEST && r_rd_d) o_ctl.best_acc = 1'b1;
        n_rd_d = o_ctl.scan_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= 1'b0;
            r_rd_d <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            r_rd_d <= n_rd_d;
        end
    end
endmodule

FILE: design/order_book_event_tracker_top.sv
// Order book event tracker: one event in, one result out. For each item, one
// pass over the slot RAM finds the order or contra key and the lowest free
// slot, then a write-back, then a second pass over the RAM rebuilds best bid
// and ask; the single RAM port serialises these steps. The result sits in an
// output register; the next item is taken as soon as the block returns to idle.
// Depends on obet_pkg, obet_ctrl, obet_datapath.
module order_book_event_tracker_top import obet_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);
    t_ctl ctl;
    t_sts sts;

    obet_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready),
        .i_sts(sts), .o_ctl(ctl)
    );

    obet_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_item(i_data), .i_ctl(ctl),
        .o_sts(sts), .o_result(o_data)
    );
endmodule

FILE: tb/sv/tb.sv
// Testbench for order_book_event_tracker_top: random and directed events
// checked against an in-bench top-of-book model held in a scoreboard class.
// Depends on obet_pkg and the design files.
module tb import obet_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    class book_scoreboard;
        logic [63:0] last_seq;
        bit          vld[MAX_ORDERS];
        logic [63:0] key[MAX_ORDERS];
        bit          side[MAX_ORDERS];
        logic [30:0] px[MAX_ORDERS];
        logic [30:0] qty[MAX_ORDERS];
        t_out_item   pending[$];
        int          errors;

        function void clear();
            last_seq = 0;
            foreach (vld[i]) vld[i] = 0;
            pending.delete();
            errors = 0;
        endfunction

        function int find_key(logic [63:0] k);
            for (int i = 0; i < MAX_ORDERS; i++)
                if (vld[i] && key[i] == k) return i;
            return -1;
        endfunction

        function int free_slots();
            int n;
            n = 0;
            foreach (vld[i]) if (!vld[i]) n++;
            return n;
        endfunction

        function void note_event(t_in_item e);
            t_out_item r;
            int s;
            longint bq, aq;
            r = '0;
            if (e.seq_num != last_seq + 64'd1) begin
                r.status = ST_REJECTED; r.reason = RS_GAP;
            end else begin
                case (e.cmd)
                    CMD_ACCEPTED, CMD_REJECTED: r.status = ST_IGNORED;
                    CMD_RESTED, CMD_PARTIAL: begin
                        if (e.remaining_qty <= 0 || e.side_code > 2'd1) begin
                            r.status = ST_REJECTED; r.reason = RS_NO_LIQ;
                        end else if (e.order_key == 0 || e.price <= 0) begin
                            r.status = ST_REJECTED; r.reason = RS_BAD_ORDER;
                        end else begin
                            s = find_key(e.order_key);
                            if (s < 0)
                                for (int i = MAX_ORDERS - 1; i >= 0; i--)
                                    if (!vld[i]) s = i;
                            if (s < 0) begin
                                r.status = ST_REJECTED; r.reason = RS_FULL;
                            end else begin
                                vld[s] = 1; key[s] = e.order_key;
                                side[s] = e.side_code[0];
                                px[s] = e.price[30:0]; qty[s] = e.remaining_qty[30:0];
                            end
                        end
                    end
                    CMD_TRADE: begin
                        if (e.trade_qty <= 0 || e.contra_key == 0) begin
                            r.status = ST_REJECTED; r.reason = RS_BAD_TRADE;
                        end else begin
                            s = find_key(e.contra_key);
                            if (s < 0) begin
                                r.status = ST_REJECTED; r.reason = RS_UNK_CONTRA;
                            end else if (longint'(qty[s]) < longint'(e.trade_qty)) begin
                                r.status = ST_REJECTED; r.reason = RS_OVERFILL;
                            end else begin
                                r.trade_valid = 1; r.trade_out_ident = e.trade_ident;
                                qty[s] = qty[s] - e.trade_qty[30:0];
                                if (qty[s] == 0) vld[s] = 0;
                            end
                        end
                    end
                    CMD_FULL: begin
                        s = find_key(e.order_key);
                        if (s < 0) r.status = ST_IGNORED;
                        else vld[s] = 0;
                    end
                    CMD_CANCEL: begin
                        s = find_key(e.order_key);
                        if (s < 0) begin
                            r.status = ST_REJECTED; r.reason = RS_UNK_CANCEL;
                        end else vld[s] = 0;
                    end
                    default: begin
                        r.status = ST_REJECTED; r.reason = RS_UNK_TYPE;
                    end
                endcase
                if (r.status != ST_REJECTED) last_seq = e.seq_num;
            end
            bq = 0; aq = 0;
            for (int i = 0; i < MAX_ORDERS; i++) begin
                if (!vld[i]) continue;
                if (!side[i]) begin
                    if (r.best_bid_price == 0 || px[i] > r.best_bid_price) begin
                        r.best_bid_price = px[i]; bq = qty[i];
                    end else if (px[i] == r.best_bid_price) bq += qty[i];
                end else begin
                    if (r.best_ask_price == 0 || px[i] < r.best_ask_price) begin
                        r.best_ask_price = px[i]; aq = qty[i];
                    end else if (px[i] == r.best_ask_price) aq += qty[i];
                end
            end
            r.best_bid_qty = (bq > QTY_MAX) ? QTY_MAX : bq[30:0];
            r.best_ask_qty = (aq > QTY_MAX) ? QTY_MAX : aq[30:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (got.status !== x.status)
                $display("%0t: status exp %0d got %0d", $time, x.status, got.status);
            if (got.reason !== x.reason)
                $display("%0t: reason exp %0d got %0d", $time, x.reason, got.reason);
            if (got.trade_valid !== x.trade_valid)
                $display("%0t: trade_valid exp %0d got %0d", $time, x.trade_valid,
                         got.trade_valid);
            if (got.trade_out_ident !== x.trade_out_ident)
                $display("%0t: trade_out_ident exp %h got %h", $time, x.trade_out_ident,
                         got.trade_out_ident);
            if (got.best_bid_price !== x.best_bid_price)
                $display("%0t: bid price exp %0d got %0d", $time, x.best_bid_price,
                         got.best_bid_price);
            if (got.best_bid_qty !== x.best_bid_qty)
                $display("%0t: bid qty exp %0d got %0d", $time, x.best_bid_qty,
                         got.best_bid_qty);
            if (got.best_ask_price !== x.best_ask_price)
                $display("%0t: ask price exp %0d got %0d", $time, x.best_ask_price,
                         got.best_ask_price);
            if (got.best_ask_qty !== x.best_ask_qty)
                $display("%0t: ask qty exp %0d got %0d", $time, x.best_ask_qty,
                         got.best_ask_qty);
            if (got !== x) errors++;
        endfunction
    endclass

    logic      i_clk, i_rst_n, i_valid, i_ready, o_ready, o_valid;
    t_in_item  i_data;
    t_out_item o_data;

    book_scoreboard book;
    logic [63:0]    next_seq;
    logic [63:0]    live_keys[$];
    longint         cycles;
    bit             hold_rx;

    order_book_event_tracker_top u_top (.*);

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 2000000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // receiver: random stalls per item, plus one long hold-off
    initial begin
        int w;
        i_ready <= 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_rx) begin
                i_ready <= 0;
                repeat (3000) @(posedge i_clk);
                hold_rx = 0;
            end
            w = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                i_ready <= 0;
                repeat (w) @(posedge i_clk);
            end
            i_ready <= 1;
            @(posedge i_clk);
            while (!(o_valid && i_ready)) @(posedge i_clk);
            book.check_result(o_data);
        end
    end

    // valid stays up after acceptance; a drain, or a wait in the next call, drops it
    task automatic send_event(t_in_item e);
        int w;
        w = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
            i_valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        i_valid <= 1;
        i_data  <= e;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        book.note_event(e);
    endtask

    function automatic t_in_item blank_event(logic [2:0] c);
        t_in_item e;
        e = '0;
        e.cmd = c;
        e.seq_num = next_seq;
        e.trade_ident = {$urandom, $urandom};
        e.instrument = $urandom;
        return e;
    endfunction

    task automatic wait_drain();
        i_valid <= 0;
        while (book.pending.size() != 0) @(posedge i_clk);
    endtask

    // send one event and keep the sequence counter in step with the book
    task automatic play(t_in_item e);
        send_event(e);
        next_seq = book.last_seq + 64'd1;
    endtask

    task automatic rest(logic [63:0] k, logic s, int p, int q);
        t_in_item e;
        e = blank_event($urandom_range(0, 1) ? CMD_RESTED : CMD_PARTIAL);
        e.order_key = k; e.side_code = {1'b0, s};
        e.price = p; e.remaining_qty = q;
        play(e);
        live_keys.insert(live_keys.size(), k);
    endtask

    function automatic logic [63:0] pick_key();
        if (live_keys.size() == 0 || $urandom_range(0, 5) == 0)
            return {$urandom, $urandom};
        return live_keys[$urandom_range(0, live_keys.size() - 1)];
    endfunction

    task automatic random_event();
        t_in_item e;
        int r;
        r = $urandom_range(0, 99);
        e = blank_event(CMD_RESTED);
        e.order_key = pick_key();
        e.side_code = ($urandom_range(0, 9) == 0) ? 2'($urandom) : 2'($urandom_range(0, 1));
        e.price = ($urandom_range(0, 19) == 0) ? int'($urandom) : $urandom_range(95, 105);
        e.remaining_qty = ($urandom_range(0, 19) == 0) ? int'($urandom)
                          : $urandom_range(1, 50);
        e.contra_key = pick_key();
        e.trade_qty = ($urandom_range(0, 19) == 0) ? int'($urandom) : $urandom_range(1, 40);
        e.price[31] = ($urandom_range(0, 30) == 0);
        if (r < 35) e.cmd = $urandom_range(0, 1) ? CMD_RESTED : CMD_PARTIAL;
        else if (r < 60) e.cmd = CMD_TRADE;
        else if (r < 70) e.cmd = CMD_FULL;
        else if (r < 82) e.cmd = CMD_CANCEL;
        else if (r < 88) e.cmd = $urandom_range(0, 1) ? CMD_ACCEPTED : CMD_REJECTED;
        else if (r < 91) e.cmd = CMD_UNKNOWN;
        else if (r < 95) e.seq_num = {$urandom, $urandom};
        else e.cmd = 3'($urandom);
        if ($urandom_range(0, 7) == 0) e.order_key = {$urandom, $urandom};
        play(e);
        if (e.cmd inside {CMD_RESTED, CMD_PARTIAL})
            live_keys.insert(live_keys.size(), e.order_key);
        if (live_keys.size() > 300) live_keys.pop_front();
    endtask

    initial begin
        t_in_item e;
        book = new();
        book.clear();
        next_seq = 1;
        hold_rx = 0;
        i_rst_n <= 0;
        i_valid <= 0;
        i_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: every event type, bad fields and extremes
        e = blank_event(CMD_ACCEPTED); e.seq_num = 0; play(e);           // gap
        e = blank_event(CMD_ACCEPTED); play(e);
        e = blank_event(CMD_REJECTED); play(e);
        e = blank_event(CMD_UNKNOWN); play(e);
        e = blank_event(CMD_RESTED); e.order_key = 5; e.price = 10;
        e.remaining_qty = 0; play(e);                                    // no liquidity
        e = blank_event(CMD_RESTED); e.order_key = 5; e.price = 10;
        e.remaining_qty = 3; e.side_code = 2'd3; play(e);
        e = blank_event(CMD_PARTIAL); e.order_key = 0; e.price = 10;
        e.remaining_qty = 3; play(e);                                    // bad order
        e = blank_event(CMD_RESTED); e.order_key = 5; e.price = 32'h8000_0000;
        e.remaining_qty = 3; play(e);
        rest(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        rest(64'd2, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);                 // saturating bid
        rest(64'd3, 1'b1, 1, 32'h7FFF_FFFF);
        rest(64'd4, 1'b1, 1, 5);
        e = blank_event(CMD_TRADE); e.contra_key = 0; e.trade_qty = 1; play(e);
        e = blank_event(CMD_TRADE); e.contra_key = 4; e.trade_qty = 0; play(e);
        e = blank_event(CMD_TRADE); e.contra_key = 99; e.trade_qty = 1; play(e);
        e = blank_event(CMD_TRADE); e.contra_key = 4; e.trade_qty = 6; play(e);
        e = blank_event(CMD_TRADE); e.contra_key = 4; e.trade_qty = 2;
        e.trade_ident = '1; play(e);
        e = blank_event(CMD_TRADE); e.contra_key = 4; e.trade_qty = 3; play(e);
        e = blank_event(CMD_FULL); e.order_key = 77; play(e);
        e = blank_event(CMD_FULL); e.order_key = 2; play(e);
        e = blank_event(CMD_CANCEL); e.order_key = 77; play(e);
        e = blank_event(CMD_CANCEL); e.order_key = 3; play(e);
        e = blank_event(CMD_ACCEPTED); e = '1; play(e);

        // sender pauses until every result is in
        wait_drain();

        // fill the table to exercise the full case, then overwrite in place
        while (book.free_slots() > 0)
            rest({$urandom, $urandom} | 64'd1, 1'($urandom_range(0, 1)),
                 $urandom_range(1, 200), $urandom_range(1, 1000));
        rest(64'hDEAD_0001, 1'b0, 50, 5);
        rest(book.key[$urandom_range(0, MAX_ORDERS - 1)], 1'b1, 90, 7);

        // long receiver stall while items keep coming
        hold_rx = 1;
        repeat (100) random_event();
        wait_drain();

        repeat (20) random_event();

        wait_drain();
        repeat (1200) @(posedge i_clk);
        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
